// ----- sv/prb_pkg.sv -----
// shared types and constants for the pixel repeat / ewma blur block
// no dependencies; imported by every module of the block

package prb_pkg;

    localparam int MAX_REPEAT_DEF = 16;
    localparam int FRAC_BITS_DEF  = 16;
    localparam int QUEUE_DEPTH    = 2;
    localparam int ACC_INT_RESET  = 64;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 5;

    localparam logic [2:0] FILTER_SHIFT_RESET = 3'd2;
    localparam logic       TV_ENABLE_RESET    = 1'b1;
    localparam logic [4:0] PIXEL_REPEAT_RESET = 5'd2;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FILTER_SHIFT = 2'd0,
        REG_TV_ENABLE    = 2'd1,
        REG_PIXEL_REPEAT = 2'd2
    } cfg_reg_t;

    typedef struct packed {
        logic [7:0] red_in;
        logic [7:0] green_in;
        logic [7:0] blue_in;
        logic       line_start;
    } pixel_in_t;

    typedef struct packed {
        logic [7:0] red_out;
        logic [7:0] green_out;
        logic [7:0] blue_out;
        logic       last_of_run;
    } pixel_out_t;

    // classified pixel as it sits in the queue
    typedef struct packed {
        logic [2:0][7:0] color;
        logic            restart;
        logic            filter;
    } job_t;

endpackage

// ----- sv/prb_front.sv -----
// front end: accepts source pixels, clamps the repeat count, tags the job
// depends on prb_pkg

module prb_front
    import prb_pkg::*;
#(
    parameter int MAX_REPEAT = MAX_REPEAT_DEF,
    parameter int CNT_W      = $clog2(MAX_REPEAT + 1)
) (
    input  logic             in_valid,
    input  pixel_in_t        in_data,
    input  logic             queue_full,
    input  logic             tv_enable,
    input  logic [4:0]       pixel_repeat,
    output logic             push,
    output job_t             job,
    output logic [CNT_W-1:0] count
);

    localparam logic [7:0] MAX_REP8 = 8'(MAX_REPEAT);

    logic [7:0] rep8;

    assign rep8 = {3'b000, pixel_repeat};
    assign push = in_valid && !queue_full;

    always_comb
    begin
        job.color[2] = in_data.red_in;
        job.color[1] = in_data.green_in;
        job.color[0] = in_data.blue_in;
        job.restart  = in_data.line_start;
        job.filter   = tv_enable;
    end

    // zero means one, anything above the limit saturates
    always_comb
    begin
        priority if (rep8 == 8'd0)
        begin
            count = CNT_W'(1);
        end
        else if (rep8 > MAX_REP8)
        begin
            count = CNT_W'(MAX_REPEAT);
        end
        else
        begin
            count = CNT_W'(rep8);
        end
    end

endmodule

// ----- sv/prb_queue.sv -----
// short fifo between front and back end, registers only
// depends on prb_pkg for the depth

module prb_queue
    import prb_pkg::*;
#(
    parameter int WIDTH = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    input  logic             pop,
    output logic             full,
    output logic             not_empty,
    output logic [WIDTH-1:0] head
);

    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [QUEUE_DEPTH];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic             do_push, do_pop;

    function automatic logic [AW-1:0] bump(input logic [AW-1:0] p);
        logic [AW-1:0] r;
        r = (p == AW'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
        return r;
    endfunction

    assign full      = (cnt_reg == CW'(QUEUE_DEPTH));
    assign not_empty = (cnt_reg != '0);
    assign head      = mem_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    always_comb
    begin
        wr_ptr_next = do_push ? bump(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = do_pop ? bump(rd_ptr_reg) : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ----- sv/prb_back.sv -----
// back end: repeats each queued pixel, runs the three ewma lanes,
// and holds the output register; depends on prb_pkg

module prb_back
    import prb_pkg::*;
#(
    parameter int MAX_REPEAT = MAX_REPEAT_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF,
    parameter int CNT_W      = $clog2(MAX_REPEAT + 1)
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             head_valid,
    input  job_t             head_job,
    input  logic [CNT_W-1:0] head_count,
    input  logic [2:0]       filter_shift,
    output logic             pop,
    output logic             out_valid,
    input  logic             out_stall,
    output pixel_out_t       out_data
);

    localparam int ACC_W = 8 + FRAC_BITS;
    localparam logic [ACC_W-1:0] ACC_RESET = ACC_W'(ACC_INT_RESET) << FRAC_BITS;

    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             out_valid_reg, out_valid_next;
    pixel_out_t       out_data_reg, out_data_next;
    logic [ACC_W-1:0] acc_reg [3];
    logic [ACC_W-1:0] acc_next [3];
    logic [7:0]       lane_out [3];
    logic             step, last;

    assign step = head_valid && (!out_valid_reg || !out_stall);
    assign last = (cnt_reg == head_count - 1'b1);
    assign pop  = step && last;

    for (genvar i = 0; i < 3; i++)
    begin : g_lane
        logic [ACC_W-1:0]      base;
        logic [ACC_W-1:0]      x;
        logic signed [ACC_W:0] diff;
        logic signed [ACC_W:0] diff_sh;
        logic signed [ACC_W:0] upd;

        // line start restores the accumulator ahead of the first repeat
        assign base    = (head_job.restart && cnt_reg == '0) ? ACC_RESET : acc_reg[i];
        assign x       = {head_job.color[i], {FRAC_BITS{1'b0}}};
        assign diff    = $signed({1'b0, x}) - $signed({1'b0, base});
        assign diff_sh = diff >>> filter_shift;
        // f + d - (d >> s) is x - (d >> s)
        assign upd     = $signed({1'b0, x}) - diff_sh;

        assign acc_next[i] = head_job.filter ? upd[ACC_W-1:0] : base;
        assign lane_out[i] = head_job.filter ? upd[ACC_W-1:FRAC_BITS] : head_job.color[i];

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                acc_reg[i] <= ACC_RESET;
            end
            else if (step)
            begin
                acc_reg[i] <= acc_next[i];
            end
        end
    end

    always_comb
    begin
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_data_next  = out_data_reg;
        if (step)
        begin
            cnt_next                  = last ? '0 : cnt_reg + 1'b1;
            out_valid_next            = 1'b1;
            out_data_next.red_out     = lane_out[2];
            out_data_next.green_out   = lane_out[1];
            out_data_next.blue_out    = lane_out[0];
            out_data_next.last_of_run = last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// ----- sv/pixel_repeat_ewma_blur_core.sv -----
// pixel repeat with ewma blur: one request in gives min(MAX_REPEAT, max(1, pixel_repeat))
// results out; from idle, the first one passes the queue registers, then the output register
// throughput: one result per cycle while out_stall is low, set by one ewma step per
// repeated result in the back end; no gap between requests
// reset: config back to shift 2, filter on, repeat 2; accumulators to 64.0
// depends on prb_pkg, prb_front, prb_queue, prb_back

module pixel_repeat_ewma_blur_core
    import prb_pkg::*;
#(
    parameter int MAX_REPEAT = MAX_REPEAT_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  pixel_in_t             in_data,
    output logic                  out_valid,
    input  logic                  out_stall,
    output pixel_out_t            out_data,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int CNT_W = $clog2(MAX_REPEAT + 1);
    localparam int Q_W   = $bits(job_t) + CNT_W;

    logic [2:0] filter_shift_reg;
    logic       tv_enable_reg;
    logic [4:0] pixel_repeat_reg;

    logic             push, pop, q_full, q_not_empty;
    job_t             push_job, head_job;
    logic [CNT_W-1:0] push_count, head_count;
    logic [Q_W-1:0]   head_word;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            filter_shift_reg <= FILTER_SHIFT_RESET;
            tv_enable_reg    <= TV_ENABLE_RESET;
            pixel_repeat_reg <= PIXEL_REPEAT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_FILTER_SHIFT: filter_shift_reg <= cfg_data[2:0];
                REG_TV_ENABLE:    tv_enable_reg    <= cfg_data[0];
                REG_PIXEL_REPEAT: pixel_repeat_reg <= cfg_data[4:0];
                default:          ;
            endcase
        end
    end

    prb_front #(
        .MAX_REPEAT (MAX_REPEAT),
        .CNT_W      (CNT_W)
    ) u_front (
        .in_valid     (in_valid),
        .in_data      (in_data),
        .queue_full   (q_full),
        .tv_enable    (tv_enable_reg),
        .pixel_repeat (pixel_repeat_reg),
        .push         (push),
        .job          (push_job),
        .count        (push_count)
    );

    assign in_stall = q_full;

    prb_queue #(
        .WIDTH (Q_W)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data ({push_job, push_count}),
        .pop       (pop),
        .full      (q_full),
        .not_empty (q_not_empty),
        .head      (head_word)
    );

    assign head_job   = job_t'(head_word[Q_W-1:CNT_W]);
    assign head_count = head_word[CNT_W-1:0];

    prb_back #(
        .MAX_REPEAT (MAX_REPEAT),
        .FRAC_BITS  (FRAC_BITS),
        .CNT_W      (CNT_W)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head_valid   (q_not_empty),
        .head_job     (head_job),
        .head_count   (head_count),
        .filter_shift (filter_shift_reg),
        .pop          (pop),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .out_data     (out_data)
    );

endmodule

// ----- sv/prb_checker.sv -----
// port-level checks for pixel_repeat_ewma_blur_core, bound to the top level
// depends on prb_pkg and pixel_repeat_ewma_blur_core

module prb_checker
    import prb_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_stall,
    input logic       out_valid,
    input logic       out_stall,
    input pixel_out_t out_data
);

    // nothing comes out right after reset lets go
    a_quiet_after_reset: assert property (@(posedge clk)
        $rose(rst_n) |-> !out_valid)
        else $error("output valid right after reset");

    // a taken request always has a result showing once it has passed the queue and output register
    a_request_reaches_output: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |-> ##2 out_valid)
        else $error("request did not reach the output in time");

    // a stalled result stays put
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
        else $error("stalled result changed or dropped");

endmodule

bind pixel_repeat_ewma_blur_core prb_checker u_prb_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);

// ----- tb/sv/pixel_repeat_ewma_blur_core_checker.sv -----
`timescale 1ns / 100ps
// result checker for pixel_repeat_ewma_blur_core: tracks config writes, predicts
// the repeated and blurred pixels of each request and compares them in order
// depends on prb_pkg

module pixel_repeat_ewma_blur_core_checker
    import prb_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic                  in_stall,
    input  pixel_in_t             in_data,
    input  logic                  out_valid,
    input  logic                  out_stall,
    input  pixel_out_t            out_data,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    fail_count,
    output int                    pending
);

    localparam int ACC_W = 8 + FRAC_BITS_DEF;
    localparam logic [ACC_W-1:0] ACC_START = ACC_W'(ACC_INT_RESET) << FRAC_BITS_DEF;

    logic [2:0]       shift_reg;
    logic             tv_reg;
    logic [4:0]       repeat_reg;
    logic [ACC_W-1:0] red_acc;
    logic [ACC_W-1:0] green_acc;
    logic [ACC_W-1:0] blue_acc;
    pixel_out_t       blurred_q[$];
    pixel_out_t       want;

    // one ewma step: f + d - (d >>> s) with d = x - f, which is x - (d >>> s)
    function automatic logic [ACC_W-1:0] blur(input logic [ACC_W-1:0] f,
                                              input logic [7:0] c,
                                              input logic [2:0] s);
        int x;
        int d;
        x = int'(c) << FRAC_BITS_DEF;
        d = x - int'(f);
        return ACC_W'(x - (d >>> s));
    endfunction

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t ns: %s", $time, msg);
        fail_count++;
    endtask

    task automatic compare_field(input string name, input logic [7:0] got,
                                 input logic [7:0] exp_val);
        if (got !== exp_val)
            report_mismatch($sformatf("%s got %0d expected %0d", name, got, exp_val));
    endtask

    task automatic expand_pixel(input pixel_in_t px);
        int reps;
        pixel_out_t res;
        reps = (repeat_reg == 0) ? 1 : int'(repeat_reg);
        if (reps > MAX_REPEAT_DEF)
            reps = MAX_REPEAT_DEF;
        // line start clears the accumulators even with the filter off
        if (px.line_start)
        begin
            red_acc   = ACC_START;
            green_acc = ACC_START;
            blue_acc  = ACC_START;
        end
        for (int k = 0; k < reps; k++)
        begin
            if (tv_reg)
            begin
                red_acc   = blur(red_acc, px.red_in, shift_reg);
                green_acc = blur(green_acc, px.green_in, shift_reg);
                blue_acc  = blur(blue_acc, px.blue_in, shift_reg);
                res.red_out   = red_acc[ACC_W-1 -: 8];
                res.green_out = green_acc[ACC_W-1 -: 8];
                res.blue_out  = blue_acc[ACC_W-1 -: 8];
            end
            else
            begin
                res.red_out   = px.red_in;
                res.green_out = px.green_in;
                res.blue_out  = px.blue_in;
            end
            res.last_of_run = (k == reps - 1);
            blurred_q.push_back(res);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shift_reg  = FILTER_SHIFT_RESET;
            tv_reg     = TV_ENABLE_RESET;
            repeat_reg = PIXEL_REPEAT_RESET;
            red_acc    = ACC_START;
            green_acc  = ACC_START;
            blue_acc   = ACC_START;
            blurred_q.delete();
            fail_count = 0;
            pending    = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_FILTER_SHIFT: shift_reg  = cfg_data[2:0];
                    REG_TV_ENABLE:    tv_reg     = cfg_data[0];
                    REG_PIXEL_REPEAT: repeat_reg = cfg_data[4:0];
                    default:          ;
                endcase
            end
            if (in_valid && !in_stall)
                expand_pixel(in_data);
            if (out_valid && !out_stall)
            begin
                if (blurred_q.size() == 0)
                    report_mismatch("result with nothing expected");
                else
                begin
                    want = blurred_q.pop_front();
                    compare_field("red_out", out_data.red_out, want.red_out);
                    compare_field("green_out", out_data.green_out, want.green_out);
                    compare_field("blue_out", out_data.blue_out, want.blue_out);
                    compare_field("last_of_run", 8'(out_data.last_of_run),
                                  8'(want.last_of_run));
                end
            end
            pending = blurred_q.size();
        end
    end

endmodule

// ----- tb/sv/pixel_repeat_ewma_blur_core_test.sv -----
`timescale 1ns / 100ps
// top of the pixel_repeat_ewma_blur_core testbench: clock, reset, config and
// pixel stimulus under several idle patterns, watchdog and verdict
// depends on prb_pkg, pixel_repeat_ewma_blur_core, pixel_repeat_ewma_blur_core_checker

module pixel_repeat_ewma_blur_core_test;
    import prb_pkg::*;

    localparam int IDLE_LIMIT  = 3000;
    localparam int NUM_PHASES  = 12;
    localparam int PHASE_ITEMS = 30;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    pixel_in_t             in_data = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    pixel_out_t            out_data;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    int                    fail_count;
    int                    pending;
    int                    send_idle_pct = 0;
    int                    recv_stall_pct = 0;
    int                    idle_cycles = 0;

    pixel_repeat_ewma_blur_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    pixel_repeat_ewma_blur_core_checker checker_inst (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_data    (in_data),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_data   (out_data),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(negedge clk)
        out_stall <= ($urandom_range(99) < recv_stall_pct);

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            idle_cycles <= 0;
        else if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else if (idle_cycles + 1 >= IDLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    function automatic logic [7:0] pick_level();
        case ($urandom_range(7))
            0:       return 8'd0;
            1:       return 8'd255;
            default: return 8'($urandom);
        endcase
    endfunction

    // called at a falling edge, returns at a falling edge
    task automatic send_pixel(input logic [7:0] r, input logic [7:0] g,
                              input logic [7:0] b, input logic ls);
        while ($urandom_range(99) < send_idle_pct)
            @(negedge clk);
        in_valid = 1'b1;
        in_data  = '{red_in: r, green_in: g, blue_in: b, line_start: ls};
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
        in_valid = 1'b0;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        @(negedge clk);
        cfg_we    = 1'b0;
    endtask

    task automatic wait_drained();
        while (pending != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    initial
    begin
        logic [2:0] shift_val;
        logic       tv_val;
        logic [4:0] rep_val;

        repeat (8) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // reset config: shift 2, filter on, repeat 2
        send_pixel(8'd0, 8'd0, 8'd0, 1'b1);
        send_pixel(8'd255, 8'd255, 8'd255, 1'b0);
        send_pixel(8'd255, 8'd0, 8'd128, 1'b0);
        send_pixel(8'd0, 8'd255, 8'd1, 1'b1);

        // shift of zero holds the accumulators
        wait_drained();
        write_reg(REG_FILTER_SHIFT, 5'd0);
        send_pixel(8'd200, 8'd100, 8'd50, 1'b0);
        send_pixel(8'd1, 8'd2, 8'd3, 1'b0);

        wait_drained();
        write_reg(REG_FILTER_SHIFT, 5'd7);
        send_pixel(8'd255, 8'd255, 8'd255, 1'b1);
        send_pixel(8'd0, 8'd0, 8'd0, 1'b0);

        // upper data bits are dropped by the 3-bit register
        wait_drained();
        write_reg(REG_FILTER_SHIFT, 5'b11001);
        send_pixel(8'd90, 8'd180, 8'd45, 1'b0);

        // filter off, line start still clears the accumulators
        wait_drained();
        write_reg(REG_TV_ENABLE, 5'b11110);
        send_pixel(8'd12, 8'd34, 8'd56, 1'b1);
        send_pixel(8'd255, 8'd0, 8'd255, 1'b0);
        wait_drained();
        write_reg(REG_TV_ENABLE, 5'd1);
        send_pixel(8'd10, 8'd20, 8'd30, 1'b0);

        // repeat of zero acts as one, above the limit saturates
        wait_drained();
        write_reg(REG_PIXEL_REPEAT, 5'd0);
        send_pixel(8'd77, 8'd88, 8'd99, 1'b0);
        wait_drained();
        write_reg(REG_PIXEL_REPEAT, 5'd31);
        send_pixel(8'd250, 8'd5, 8'd128, 1'b0);
        wait_drained();
        write_reg(REG_PIXEL_REPEAT, 5'd16);
        send_pixel(8'd3, 8'd254, 8'd64, 1'b1);
        wait_drained();
        write_reg(REG_PIXEL_REPEAT, 5'd17);
        send_pixel(8'd128, 8'd127, 8'd129, 1'b0);
        wait_drained();
        write_reg(REG_PIXEL_REPEAT, 5'd1);
        send_pixel(8'd40, 8'd41, 8'd42, 1'b0);

        // write to an unused index is ignored
        wait_drained();
        write_reg(REG_UNUSED, 5'd0);
        send_pixel(8'd200, 8'd201, 8'd202, 1'b0);

        for (int phase = 0; phase < NUM_PHASES; phase++)
        begin
            wait_drained();
            shift_val = 3'($urandom);
            tv_val    = ($urandom_range(3) != 0);
            case ($urandom_range(9))
                0, 1, 2, 3, 4, 5: rep_val = 5'($urandom_range(4, 1));
                6:                rep_val = 5'd0;
                7:                rep_val = 5'd16;
                8:                rep_val = 5'($urandom_range(31, 17));
                default:          rep_val = 5'($urandom_range(15, 5));
            endcase
            write_reg(REG_FILTER_SHIFT, {2'($urandom), shift_val});
            write_reg(REG_TV_ENABLE, {4'($urandom), tv_val});
            write_reg(REG_PIXEL_REPEAT, rep_val);
            case (phase % 4)
                0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1:       begin send_idle_pct = 80; recv_stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  recv_stall_pct = 80; end
                default: begin send_idle_pct = 34; recv_stall_pct = 34; end
            endcase
            for (int k = 0; k < PHASE_ITEMS; k++)
            begin
                // hold off mid phase until the block has emptied
                if (k == PHASE_ITEMS / 2)
                    while (pending != 0)
                        @(negedge clk);
                send_pixel(pick_level(), pick_level(), pick_level(),
                           (k == 0) || ($urandom_range(7) == 0));
            end
        end

        while (pending != 0)
            @(negedge clk);
        repeat (10) @(negedge clk);
        if (fail_count == 0 && pending == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ----- filelist.f -----
sv/prb_pkg.sv
sv/prb_front.sv
sv/prb_queue.sv
sv/prb_back.sv
sv/pixel_repeat_ewma_blur_core.sv
sv/prb_checker.sv
tb/sv/pixel_repeat_ewma_blur_core_checker.sv
tb/sv/pixel_repeat_ewma_blur_core_test.sv
